// ===== src/bdhr_pkg.sv =====
// Shared types and constants for the button debounce / hold / repeat unit.
// No dependencies.
package bdhr_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LEVEL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_ENABLE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TIME       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE        = 3'd4;

  // Reset values
  localparam logic [15:0] HOLD_TIME_RST       = 16'd1000;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd200;
  localparam logic [15:0] DEBOUNCE_RST        = 16'd50;

  // Button phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_HELD    = 2'd2
  } phase_t;

  // Configuration set seen by the core
  typedef struct packed {
    logic        active_level;
    logic        repeat_enable;
    logic [15:0] hold_time_ms;
    logic [15:0] repeat_interval_ms;
    logic [15:0] debounce_ms;
  } cfg_t;

endpackage

// ===== src/bdhr_cfg.sv =====
// Configuration register bank for the button debounce / hold / repeat unit.
// Depends on bdhr_pkg.
module bdhr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdhr_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bdhr_pkg::cfg_t                   cfg
);
  import bdhr_pkg::*;

  cfg_t regs;

  // Register writes; zero writes to hold time and repeat interval are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.active_level       <= 1'b0;
      regs.repeat_enable      <= 1'b0;
      regs.hold_time_ms       <= HOLD_TIME_RST;
      regs.repeat_interval_ms <= REPEAT_INTERVAL_RST;
      regs.debounce_ms        <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL:    regs.active_level  <= cfg_data[0];
        REG_REPEAT_ENABLE:   regs.repeat_enable <= cfg_data[0];
        REG_HOLD_TIME: begin
          if (cfg_data != '0) regs.hold_time_ms <= cfg_data;
        end
        REG_REPEAT_INTERVAL: begin
          if (cfg_data != '0) regs.repeat_interval_ms <= cfg_data;
        end
        REG_DEBOUNCE:        regs.debounce_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== src/bdhr_core.sv =====
// Debounce / hold / repeat state machine; one poll is evaluated per step.
// Depends on bdhr_pkg.
module bdhr_core #(
  parameter int TIME_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [31:0]    now_ms,
  input  logic           pin_level,
  input  bdhr_pkg::cfg_t cfg,
  output logic           impulse,
  output logic           held
);
  import bdhr_pkg::*;

  phase_t               phase, phase_next;
  logic [TIME_BITS-1:0] debounce_until, debounce_until_next;
  logic [TIME_BITS-1:0] press_time, press_time_next;
  logic [TIME_BITS-1:0] next_repeat_time, next_repeat_time_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] debounce_deadline;
  logic [TIME_BITS-1:0] hold_deadline;
  logic [TIME_BITS-1:0] repeat_deadline;
  logic                 pressed;
  logic                 lock_over;
  logic                 hold_reached;
  logic                 repeat_due;

  // Time arithmetic, wrapping at TIME_BITS
  assign now_t             = TIME_BITS'(now_ms);
  assign pressed           = (pin_level == cfg.active_level);
  assign debounce_deadline = now_t + TIME_BITS'(cfg.debounce_ms);
  assign hold_deadline     = press_time + TIME_BITS'(cfg.hold_time_ms);
  assign repeat_deadline   = now_t + TIME_BITS'(cfg.repeat_interval_ms);
  assign lock_over         = (now_t >= debounce_until);
  assign hold_reached      = (now_t >= hold_deadline);
  assign repeat_due        = cfg.repeat_enable && (now_t >= next_repeat_time);

  // Next phase; a release seen after the debounce lock beats entry to held
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_PRESSED: begin
        if (lock_over && !pressed) phase_next = PH_IDLE;
        else if (hold_reached)     phase_next = PH_HELD;
      end
      PH_HELD: begin
        if (!pressed) phase_next = PH_IDLE;
      end
      default: begin
        if (lock_over && pressed) phase_next = PH_PRESSED;
        else                      phase_next = PH_IDLE;
      end
    endcase
  end

  // Timestamps and impulse
  always_comb begin
    debounce_until_next   = debounce_until;
    press_time_next       = press_time;
    next_repeat_time_next = next_repeat_time;
    impulse               = 1'b0;
    case (phase)
      PH_PRESSED: begin
        if (lock_over && !pressed) debounce_until_next = debounce_deadline;
      end
      PH_HELD: begin
        if (!pressed) begin
          debounce_until_next = debounce_deadline;
        end else if (repeat_due) begin
          next_repeat_time_next = repeat_deadline;
          impulse               = 1'b1;
        end
      end
      default: begin
        if (lock_over && pressed) begin
          press_time_next     = now_t;
          debounce_until_next = debounce_deadline;
          impulse             = 1'b1;
        end
      end
    endcase
  end

  assign held = (phase_next == PH_HELD);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      debounce_until   <= '0;
      press_time       <= '0;
      next_repeat_time <= '0;
    end else if (step) begin
      phase            <= phase_next;
      debounce_until   <= debounce_until_next;
      press_time       <= press_time_next;
      next_repeat_time <= next_repeat_time_next;
    end
  end

endmodule

// ===== src/button_debounce_hold_repeat_unit.sv =====
// Top level of the button debounce / hold / repeat unit.
// Depends on bdhr_pkg, bdhr_cfg and bdhr_core.
//
// Usage:
//   Each input transaction on in_valid/in_ready is one poll: the millisecond
//   time now_ms and the sampled pin_level. Each poll yields exactly one
//   output transaction on out_valid/out_ready carrying impulse (press or
//   repeat) and held (phase after the poll).
//   Polls land in an input register, are evaluated by the state machine and
//   written to an output register once that is free or being emptied; the
//   core state and the output register update at the same edge. Throughput
//   is one poll per cycle while out_ready stays high, as the core updates
//   its state on every poll that moves on.
//   When the receiver stalls, the result waits in the output register, one
//   further poll waits in the input register, then in_ready drops.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect on the
//   next edge and should be made with no poll in flight.
//   Reset (rst, synchronous) empties both registers, returns to idle with
//   all timestamps zero and loads the register defaults.
//   TIME_BITS sets the width of the internal time base; now_ms is truncated
//   or zero-extended to it and all sums wrap at that width.
module button_debounce_hold_repeat_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bdhr_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     now_ms,
  input  logic                            pin_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            impulse,
  output logic                            held
);
  import bdhr_pkg::*;

  cfg_t        cfg;
  logic        in_full;
  logic [31:0] in_now;
  logic        in_pin;
  logic        advance;
  logic        core_impulse;
  logic        core_held;

  bdhr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Poll moves on when the output register is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_now <= now_ms;
      in_pin <= pin_level;
    end
  end

  bdhr_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .now_ms    (in_now),
    .pin_level (in_pin),
    .cfg       (cfg),
    .impulse   (core_impulse),
    .held      (core_held)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      impulse <= core_impulse;
      held    <= core_held;
    end
  end

endmodule
